// File: hdl/matrix_product_transpose_modes_core_assert.svh
// assertion macros shared by the matrix product core
`ifndef MATRIX_PRODUCT_TRANSPOSE_MODES_CORE_ASSERT_SVH
`define MATRIX_PRODUCT_TRANSPOSE_MODES_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MPTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mptm assertion failed");

// next-cycle implication, disabled during reset
`define MPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mptm assertion failed");

`endif

// File: hdl/mptm_pkg.sv
// shared constants and codes of the matrix product core
`timescale 1ns / 1ps
`default_nettype none

package mptm_pkg;

	localparam int MAX_DIM_DEF   = 16;
	localparam int ELEM_BITS_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 4;
	localparam int VALUE_W = 16;
	localparam int OUT_W   = 36;
	localparam int REG_W   = 2;
	localparam int CFG_W   = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_A = 2'd0,
		CMD_WRITE_X = 2'd1,
		CMD_READ_B  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_A_X  = 2'd0,
		MODE_AT_X = 2'd1,
		MODE_A_XT = 2'd2
	} mode_t;

	typedef enum logic [REG_W-1:0] {
		REG_MODE      = 2'd0,
		REG_ROWS_A    = 2'd1,
		REG_COLS_A    = 2'd2,
		REG_OTHER_DIM = 2'd3
	} reg_idx_t;

	localparam logic [1:0]       MODE_RESET = 2'd0;
	localparam logic [CFG_W-1:0] DIM_RESET  = 5'd16;

endpackage

`default_nettype wire

// File: hdl/mptm_if.sv
// valid/ready channel interfaces of the matrix product core
`timescale 1ns / 1ps
`default_nettype none

interface mptm_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [mptm_pkg::CMD_W-1:0]          command;
	logic [mptm_pkg::IDX_W-1:0]          row;
	logic [mptm_pkg::IDX_W-1:0]          col;
	logic signed [mptm_pkg::VALUE_W-1:0] value;

	modport source (output valid, output command, output row, output col, output value,
		input ready);
	modport sink (input valid, input command, input row, input col, input value,
		output ready);
endinterface

interface mptm_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [mptm_pkg::OUT_W-1:0] product_value;
	logic                              out_of_range;

	modport source (output valid, output product_value, output out_of_range, input ready);
	modport sink (input valid, input product_value, input out_of_range, output ready);
endinterface

interface mptm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mptm_pkg::REG_W-1:0] index;
	logic [mptm_pkg::CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/matrix_product_transpose_modes_core.sv
// matrix product core: element stores A and X, product entries by one shared multiply-accumulate
// sequence: a read beat in range passes S_ISSUE, S_DRAIN and S_LOAD before its result is
// registered; an out-of-range or empty-inner read goes straight to S_LOAD
// throughput: the single multiply-accumulate walks the inner dimension one term per cycle through
// one read port per store; writes one per cycle, taken only while no read is in progress
// reset: mode A*X, all dimensions 16, no result pending; store contents undefined until written
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_product_transpose_modes_core_assert.svh"

module matrix_product_transpose_modes_core #(
	parameter int MAX_DIM   = mptm_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mptm_pkg::ELEM_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	mptm_cmd_if.sink    cmd,
	mptm_res_if.source  result,
	mptm_cfg_if.sink    cfg
);

	// dimension width holds MAX_DIM itself; compare width also covers 5-bit regs and 4-bit indexes
	localparam int DW        = $clog2(MAX_DIM + 1);
	localparam int CW        = (DW > mptm_pkg::CFG_W) ? DW : mptm_pkg::CFG_W;
	localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int PW        = 2 * ELEM_BITS;
	localparam int OW        = mptm_pkg::OUT_W;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_DRAIN = 4'b0100,
		S_LOAD  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0]                    prod_mode_q;
	logic [mptm_pkg::CFG_W-1:0]    rows_a_q;
	logic [mptm_pkg::CFG_W-1:0]    cols_a_q;
	logic [mptm_pkg::CFG_W-1:0]    other_dim_q;

	// latched read command
	mptm_pkg::mode_t               mode_q;
	logic [DW-1:0]                 row_q;
	logic [DW-1:0]                 col_q;
	logic [DW-1:0]                 inner_q;
	logic [DW-1:0]                 j_q;
	logic                          oor_q;

	// multiply-accumulate pipeline
	logic                          v_s1;
	logic                          v_s2;
	logic signed [ELEM_BITS-1:0]   a_rd_s1;
	logic signed [ELEM_BITS-1:0]   x_rd_s1;
	logic signed [PW-1:0]          prod_s2;
	logic signed [OW-1:0]          acc_q;

	// output register
	logic                          out_valid_q;
	logic signed [OW-1:0]          out_value_q;
	logic                          out_oor_q;

	// element stores
	logic [ELEM_BITS-1:0]          a_mem_q [MEM_DEPTH];
	logic [ELEM_BITS-1:0]          x_mem_q [MEM_DEPTH];

	logic                          cmd_beat;
	logic                          wr_in_range;
	logic                          a_we;
	logic                          x_we;
	logic                          rd_cmd;
	logic                          issue;
	logic                          load_out;
	logic [AW-1:0]                 wr_addr;
	logic [AW-1:0]                 a_rd_addr;
	logic [AW-1:0]                 x_rd_addr;
	logic [AW-1:0]                 a_addr;
	logic [AW-1:0]                 x_addr;
	logic signed [ELEM_BITS-1:0]   wr_data;
	logic [DW-1:0]                 ra_dim;
	logic [DW-1:0]                 ca_dim;
	logic [DW-1:0]                 od_dim;
	mptm_pkg::mode_t               mode_in;
	logic [DW-1:0]                 b_rows_in;
	logic [DW-1:0]                 inner_in;
	logic                          oor_in;
	logic [DW-1:0]                 a_row;
	logic [DW-1:0]                 a_col;
	logic [DW-1:0]                 x_row;
	logic [DW-1:0]                 x_col;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_beat  = cmd.valid && cmd.ready;

	assign result.valid         = out_valid_q;
	assign result.product_value = out_value_q;
	assign result.out_of_range  = out_oor_q;

	// dimension registers saturate at MAX_DIM
	assign ra_dim = (CW'(rows_a_q) > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rows_a_q);
	assign ca_dim = (CW'(cols_a_q) > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cols_a_q);
	assign od_dim = (CW'(other_dim_q) > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(other_dim_q);

	// mode code 3 behaves as A*X
	always_comb begin
		unique case (prod_mode_q)
			mptm_pkg::MODE_AT_X: mode_in = mptm_pkg::MODE_AT_X;
			mptm_pkg::MODE_A_XT: mode_in = mptm_pkg::MODE_A_XT;
			default:             mode_in = mptm_pkg::MODE_A_X;
		endcase
	end

	// shape of B: A'*X has cols_a rows and sums over rows_a
	assign b_rows_in = (mode_in == mptm_pkg::MODE_AT_X) ? ca_dim : ra_dim;
	assign inner_in  = (mode_in == mptm_pkg::MODE_AT_X) ? ra_dim : ca_dim;
	assign oor_in    = (CW'(cmd.row) >= CW'(b_rows_in)) || (CW'(cmd.col) >= CW'(od_dim));

	// command decode
	assign wr_in_range = (CW'(cmd.row) < CW'(MAX_DIM)) && (CW'(cmd.col) < CW'(MAX_DIM));
	assign a_we   = cmd_beat && wr_in_range && (cmd.command == mptm_pkg::CMD_WRITE_A);
	assign x_we   = cmd_beat && wr_in_range && (cmd.command == mptm_pkg::CMD_WRITE_X);
	assign rd_cmd = cmd_beat && (cmd.command == mptm_pkg::CMD_READ_B);

	// narrow elements keep their low bits, wide ones sign-extend
	assign wr_data = ELEM_BITS'(cmd.value);
	assign wr_addr = AW'(cmd.row) * AW'(MAX_DIM) + AW'(cmd.col);

	// operand indexes for inner term j
	assign a_row = (mode_q == mptm_pkg::MODE_AT_X) ? j_q : row_q;
	assign a_col = (mode_q == mptm_pkg::MODE_AT_X) ? row_q : j_q;
	assign x_row = (mode_q == mptm_pkg::MODE_A_XT) ? col_q : j_q;
	assign x_col = (mode_q == mptm_pkg::MODE_A_XT) ? j_q : col_q;

	assign a_rd_addr = AW'(a_row) * AW'(MAX_DIM) + AW'(a_col);
	assign x_rd_addr = AW'(x_row) * AW'(MAX_DIM) + AW'(x_col);

	// one port per store: writes only happen while idle, read data is used only while issuing
	assign a_addr = a_we ? wr_addr : a_rd_addr;
	assign x_addr = x_we ? wr_addr : x_rd_addr;

	assign issue    = (state_q == S_ISSUE);
	assign load_out = (state_q == S_LOAD) && (!out_valid_q || result.ready);

	// store arrays with registered read data
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem_q[a_addr] <= wr_data;
		end
		a_rd_s1 <= a_mem_q[a_addr];
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem_q[x_addr] <= wr_data;
		end
		x_rd_s1 <= x_mem_q[x_addr];
	end

	// product stage, no reset on payload
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * x_rd_s1;
	end

	// configuration write beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_mode_q <= mptm_pkg::MODE_RESET;
			rows_a_q    <= mptm_pkg::DIM_RESET;
			cols_a_q    <= mptm_pkg::DIM_RESET;
			other_dim_q <= mptm_pkg::DIM_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				mptm_pkg::REG_MODE:      prod_mode_q <= cfg.data[1:0];
				mptm_pkg::REG_ROWS_A:    rows_a_q    <= cfg.data;
				mptm_pkg::REG_COLS_A:    cols_a_q    <= cfg.data;
				mptm_pkg::REG_OTHER_DIM: other_dim_q <= cfg.data;
			endcase
		end
	end

	// sequencer, pipeline valids, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= mptm_pkg::MODE_A_X;
			row_q       <= '0;
			col_q       <= '0;
			inner_q     <= '0;
			j_q         <= '0;
			oor_q       <= 1'b0;
			acc_q       <= '0;
			out_value_q <= '0;
			out_oor_q   <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;

			if (v_s2) begin
				acc_q <= acc_q + OW'(prod_s2);
			end

			// result taken downstream frees the output register unless a new one lands
			if (result.valid && result.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (rd_cmd) begin
						mode_q  <= mode_in;
						row_q   <= DW'(cmd.row);
						col_q   <= DW'(cmd.col);
						inner_q <= inner_in;
						j_q     <= '0;
						oor_q   <= oor_in;
						acc_q   <= '0;
						// out of range or empty inner sum goes straight to the result
						if (oor_in || (inner_in == '0)) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					j_q <= j_q + 1'b1;
					if (j_q == inner_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last term has left both pipeline stages
					if (!v_s1 && !v_s2) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_value_q <= oor_q ? '0 : acc_q;
						out_oor_q   <= oor_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an out-of-range read skips the multiply-accumulate walk
	`MPTM_ASSERT_NEXT(a_oor_skips, clk, arst_n, rd_cmd && oor_in, state_q == S_LOAD)
	// pipeline is empty whenever a new command can be taken
	`MPTM_ASSERT_NOW(a_idle_empty, clk, arst_n, state_q == S_IDLE, !v_s1 && !v_s2)
	// term index never passes the inner dimension
	`MPTM_ASSERT_NOW(a_j_bound, clk, arst_n, state_q == S_ISSUE, j_q < inner_q)
	// a pending result is never overwritten
	`MPTM_ASSERT_NEXT(a_load_holds, clk, arst_n,
		(state_q == S_LOAD) && out_valid_q && !result.ready, state_q == S_LOAD)
	// a flagged result carries zero
	`MPTM_ASSERT_NOW(a_oor_zero, clk, arst_n, out_valid_q && out_oor_q, out_value_q == '0)

endmodule

`default_nettype wire
